/* sv/rgbc_pkg.sv */
package rgbc_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DIM_W          = 11;
    localparam int POS_W          = 10;
    localparam int SUM_W          = 14;
    localparam int BOX_RECIP      = 3641;   // 2^15 / 9, exact for sums below 2300
    localparam int BOX_RECIP_SH   = 15;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_FILTER_MODE  = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_EDGE    = 2'd0,
        MODE_SHARPEN = 2'd1,
        MODE_BOX     = 2'd2,
        MODE_GAUSS   = 2'd3
    } filter_mode_t;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pix_t;

    // index 0 is the top row of the column
    typedef pix_t [2:0] column_t;

    typedef struct packed {
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic [7:0]       out_red;
        logic [7:0]       out_green;
        logic [7:0]       out_blue;
        logic             pass_through;
        logic             frame_done;
    } res_t;

    // round, scale and clamp a raw kernel sum
    function automatic logic [7:0] scale_clamp(input logic signed [SUM_W-1:0] sum,
                                               input filter_mode_t mode);
        logic [11:0]             box_x;
        logic [23:0]             box_p;
        logic signed [SUM_W-1:0] g;
        logic signed [SUM_W-1:0] v;
        box_x = 12'(sum + 14'sd4);
        box_p = {12'd0, box_x} * 24'(BOX_RECIP);
        g     = (sum + 14'sd8) >>> 4;
        unique case (mode)
            MODE_BOX:   v = signed'({5'd0, box_p[BOX_RECIP_SH +: 9]});
            MODE_GAUSS: v = g;
            default:    v = sum;
        endcase
        if (v < 0)
            scale_clamp = 8'd0;
        else if (v > 14'sd255)
            scale_clamp = 8'd255;
        else
            scale_clamp = v[7:0];
    endfunction

endpackage

/* sv/rgbc_pix_if.sv */
interface rgbc_pix_if;
    logic          valid;
    logic          ready;
    rgbc_pkg::pix_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/rgbc_res_if.sv */
interface rgbc_res_if;
    logic          valid;
    logic          ready;
    rgbc_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/rgb_convolution_3x3_filter_core.sv */
// 3x3 rgb convolution filter. pixels of a region arrive in raster order on pix, one beat
// per pixel; results leave on res tagged with row and column. the block takes one pixel
// per clock while it is not stalled: a pixel is read against the two line stores in the
// cycle it is accepted, the window (a chain of two column cells plus the fresh column) is
// summed into the stage 2 registers, and from these the result is scaled, rounded and
// clamped into a single output register. one result beat leaves per clock while res
// ready is high; a pixel that makes more than one result holds pix until all have left:
// the right-border pixel of an interior row and every last-row pixel past column 0 make
// two beats, and the right-border pixel of the last row three. all other pixels go at one
// per clock with res ready held high. border rows and columns come out unchanged with
// pass_through set; frame_done marks the last beat of a region. writing frame_width or
// frame_height restarts the region and is done with the block idle; widths and heights
// below 3 act as 3, above MAX_WIDTH / MAX_HEIGHT as the maximum. line stores are not
// cleared after reset and need no clearing pass.
module rgb_convolution_3x3_filter_core #(
    parameter int MAX_WIDTH  = rgbc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgbc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [1:0]                wr_index,
    input  logic [rgbc_pkg::DIM_W-1:0] wr_data,
    rgbc_pix_if.sink                  pix,
    rgbc_res_if.source                res
);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int HW  = $clog2(MAX_HEIGHT);
    localparam int WW0 = $clog2(MAX_WIDTH + 1);
    localparam int HW0 = $clog2(MAX_HEIGHT + 1);
    localparam int CWW = (WW0 > rgbc_pkg::DIM_W) ? WW0 : rgbc_pkg::DIM_W;
    localparam int CHW = (HW0 > rgbc_pkg::DIM_W) ? HW0 : rgbc_pkg::DIM_W;

    // result slots in emission order
    localparam int SL_TOP    = 0;
    localparam int SL_LEFT   = 1;
    localparam int SL_FILT   = 2;
    localparam int SL_RIGHT  = 3;
    localparam int SL_BOTTOM = 4;

    // configuration
    logic [rgbc_pkg::DIM_W-1:0] width_reg;
    logic [rgbc_pkg::DIM_W-1:0] height_reg;
    rgbc_pkg::filter_mode_t     mode_reg;

    logic [CWW-1:0] w_ext;
    logic [CHW-1:0] h_ext;
    logic [CWW-1:0] w_eff;
    logic [CHW-1:0] h_eff;

    // raster position
    logic [AW-1:0] col_reg;
    logic [HW-1:0] row_reg;
    logic          accept;
    logic          col_last;
    logic          row_last;
    logic [4:0]    slot_mask;

    // stage 1: line store reads
    logic          s1_valid_reg;
    logic [4:0]    s1_mask_reg;
    logic [AW-1:0] s1_col_reg;
    logic [HW-1:0] s1_row_reg;
    logic          s1_last_reg;
    rgbc_pkg::pix_t s1_pix_reg;
    rgbc_pkg::pix_t upper_rd_reg;
    rgbc_pkg::pix_t middle_rd_reg;

    rgbc_pkg::pix_t upper_mem  [MAX_WIDTH];
    rgbc_pkg::pix_t middle_mem [MAX_WIDTH];

    // window chain
    rgbc_pkg::column_t fresh_col;
    rgbc_pkg::column_t mid_col;
    rgbc_pkg::column_t old_col;
    logic              shift;
    logic [2:0][2:0][2:0][7:0] win;    // [channel][column][row]
    logic signed [rgbc_pkg::SUM_W-1:0] sums [3];

    // stage 2: result slots
    logic [4:0]    s2_mask_reg;
    logic [4:0]    s2_mask_next;
    logic [AW-1:0] s2_col_reg;
    logic [HW-1:0] s2_row_reg;
    logic          s2_last_reg;
    logic signed [rgbc_pkg::SUM_W-1:0] s2_sum_reg [3];
    rgbc_pkg::pix_t s2_center_reg;
    rgbc_pkg::pix_t s2_middle_reg;
    rgbc_pkg::pix_t s2_pix_reg;
    logic [4:0]    pick;
    logic [4:0]    mask_left;
    logic          pop;
    logic          s2_ready;

    // output register
    logic           res_valid_reg;
    rgbc_pkg::res_t res_reg;
    rgbc_pkg::res_t res_next;
    logic           out_load;
    logic [HW-1:0]  row_up;

    // effective geometry
    always_comb
    begin
        w_ext = CWW'(width_reg);
        h_ext = CHW'(height_reg);
        if (w_ext < CWW'(3))
            w_eff = CWW'(3);
        else if (w_ext > CWW'(MAX_WIDTH))
            w_eff = CWW'(MAX_WIDTH);
        else
            w_eff = w_ext;
        if (h_ext < CHW'(3))
            h_eff = CHW'(3);
        else if (h_ext > CHW'(MAX_HEIGHT))
            h_eff = CHW'(MAX_HEIGHT);
        else
            h_eff = h_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rgbc_pkg::DIM_W'(3);
            height_reg <= rgbc_pkg::DIM_W'(3);
            mode_reg   <= rgbc_pkg::MODE_EDGE;
        end
        else if (wr_en)
        begin
            unique case (rgbc_pkg::reg_index_t'(wr_index))
                rgbc_pkg::REG_FRAME_WIDTH:  width_reg  <= wr_data;
                rgbc_pkg::REG_FRAME_HEIGHT: height_reg <= wr_data;
                rgbc_pkg::REG_FILTER_MODE:  mode_reg   <= rgbc_pkg::filter_mode_t'(wr_data[1:0]);
                default: ;
            endcase
        end
    end

    // position and which results this pixel will make
    assign pix.ready = s2_ready;
    assign accept    = pix.valid && s2_ready;
    assign col_last  = (CWW'(col_reg) == w_eff - CWW'(1));
    assign row_last  = (CHW'(row_reg) == h_eff - CHW'(1));

    always_comb
    begin
        logic ge2;
        ge2 = (row_reg >= HW'(2));
        slot_mask            = '0;
        slot_mask[SL_TOP]    = (row_reg == '0);
        slot_mask[SL_LEFT]   = ge2 && (col_reg == AW'(1));
        slot_mask[SL_FILT]   = ge2 && (col_reg >= AW'(2));
        slot_mask[SL_RIGHT]  = ge2 && col_last;
        slot_mask[SL_BOTTOM] = ge2 && row_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (wr_en && (wr_index == rgbc_pkg::REG_FRAME_WIDTH
                        || wr_index == rgbc_pkg::REG_FRAME_HEIGHT))
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_reg <= '0;
                row_reg <= row_last ? '0 : row_reg + HW'(1);
            end
            else
                col_reg <= col_reg + AW'(1);
        end
    end

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s2_ready)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mask_reg   <= slot_mask;
            s1_col_reg    <= col_reg;
            s1_row_reg    <= row_reg;
            s1_last_reg   <= col_last;
            s1_pix_reg    <= pix.data;
            upper_rd_reg  <= upper_mem[col_reg];
            middle_rd_reg <= middle_mem[col_reg];
        end
        // rows move up one store as the window passes
        if (shift)
        begin
            upper_mem[s1_col_reg]  <= middle_rd_reg;
            middle_mem[s1_col_reg] <= s1_pix_reg;
        end
    end

    // window: fresh column feeds the chain of column cells
    assign shift     = s1_valid_reg && s2_ready;
    assign fresh_col = {s1_pix_reg, middle_rd_reg, upper_rd_reg};

    rgbc_cell u_cell_mid (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (shift),
        .col_in  (fresh_col),
        .col_out (mid_col)
    );

    rgbc_cell u_cell_old (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (shift),
        .col_in  (mid_col),
        .col_out (old_col)
    );

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win[0][0][r] = old_col[r].in_red;
            win[0][1][r] = mid_col[r].in_red;
            win[0][2][r] = fresh_col[r].in_red;
            win[1][0][r] = old_col[r].in_green;
            win[1][1][r] = mid_col[r].in_green;
            win[1][2][r] = fresh_col[r].in_green;
            win[2][0][r] = old_col[r].in_blue;
            win[2][1][r] = mid_col[r].in_blue;
            win[2][2][r] = fresh_col[r].in_blue;
        end
    end

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_conv
        rgbc_conv u_conv (
            .win  (win[ch]),
            .mode (mode_reg),
            .sum  (sums[ch])
        );
    end

    // stage 2: hand out one slot per beat, lowest first
    assign pick      = s2_mask_reg & (~s2_mask_reg + 5'd1);
    assign out_load  = !res_valid_reg || res.ready;
    assign pop       = (s2_mask_reg != '0) && out_load;
    assign mask_left = pop ? (s2_mask_reg & ~pick) : s2_mask_reg;
    assign s2_ready  = (mask_left == '0);

    always_comb
    begin
        if (s2_ready)
            s2_mask_next = s1_valid_reg ? s1_mask_reg : '0;
        else
            s2_mask_next = mask_left;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_mask_reg <= '0;
        else
            s2_mask_reg <= s2_mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            s2_col_reg    <= s1_col_reg;
            s2_row_reg    <= s1_row_reg;
            s2_last_reg   <= s1_last_reg;
            s2_sum_reg    <= sums;
            s2_center_reg <= mid_col[1];
            s2_middle_reg <= middle_rd_reg;
            s2_pix_reg    <= s1_pix_reg;
        end
    end

    assign row_up = s2_row_reg - HW'(1);

    always_comb
    begin
        res_next              = '0;
        res_next.pass_through = 1'b1;
        priority if (pick[SL_TOP])
        begin
            res_next.out_row   = '0;
            res_next.out_col   = rgbc_pkg::POS_W'(s2_col_reg);
            res_next.out_red   = s2_pix_reg.in_red;
            res_next.out_green = s2_pix_reg.in_green;
            res_next.out_blue  = s2_pix_reg.in_blue;
        end
        else if (pick[SL_LEFT])
        begin
            res_next.out_row   = rgbc_pkg::POS_W'(row_up);
            res_next.out_col   = '0;
            res_next.out_red   = s2_center_reg.in_red;
            res_next.out_green = s2_center_reg.in_green;
            res_next.out_blue  = s2_center_reg.in_blue;
        end
        else if (pick[SL_FILT])
        begin
            res_next.out_row      = rgbc_pkg::POS_W'(row_up);
            res_next.out_col      = rgbc_pkg::POS_W'(s2_col_reg - AW'(1));
            res_next.out_red      = rgbc_pkg::scale_clamp(s2_sum_reg[0], mode_reg);
            res_next.out_green    = rgbc_pkg::scale_clamp(s2_sum_reg[1], mode_reg);
            res_next.out_blue     = rgbc_pkg::scale_clamp(s2_sum_reg[2], mode_reg);
            res_next.pass_through = 1'b0;
        end
        else if (pick[SL_RIGHT])
        begin
            res_next.out_row   = rgbc_pkg::POS_W'(row_up);
            res_next.out_col   = rgbc_pkg::POS_W'(s2_col_reg);
            res_next.out_red   = s2_middle_reg.in_red;
            res_next.out_green = s2_middle_reg.in_green;
            res_next.out_blue  = s2_middle_reg.in_blue;
        end
        else
        begin
            res_next.out_row    = rgbc_pkg::POS_W'(s2_row_reg);
            res_next.out_col    = rgbc_pkg::POS_W'(s2_col_reg);
            res_next.out_red    = s2_pix_reg.in_red;
            res_next.out_green  = s2_pix_reg.in_green;
            res_next.out_blue   = s2_pix_reg.in_blue;
            res_next.frame_done = s2_last_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (out_load)
            res_valid_reg <= pop;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            res_reg <= res_next;
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;
endmodule

/* sv/rgbc_cell.sv */
// one window column, handed on to the older neighbor on each shift
module rgbc_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  rgbc_pkg::column_t col_in,
    output rgbc_pkg::column_t col_out
);
    rgbc_pkg::column_t col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col_reg <= '0;
        else if (shift)
            col_reg <= col_in;
    end

    assign col_out = col_reg;
endmodule

/* sv/rgbc_conv.sv */
// raw 3x3 kernel sum for one channel, mode picks the weights
module rgbc_conv (
    input  logic [2:0][2:0][7:0]              win,  // [column][row]
    input  rgbc_pkg::filter_mode_t            mode,
    output logic signed [rgbc_pkg::SUM_W-1:0] sum
);
    logic signed [rgbc_pkg::SUM_W-1:0] ctr;
    logic signed [rgbc_pkg::SUM_W-1:0] edges;
    logic signed [rgbc_pkg::SUM_W-1:0] corners;

    always_comb
    begin
        ctr     = signed'({6'd0, win[1][1]});
        edges   = signed'({6'd0, win[1][0]}) + signed'({6'd0, win[1][2]})
                + signed'({6'd0, win[0][1]}) + signed'({6'd0, win[2][1]});
        corners = signed'({6'd0, win[0][0]}) + signed'({6'd0, win[0][2]})
                + signed'({6'd0, win[2][0]}) + signed'({6'd0, win[2][2]});
        unique case (mode)
            rgbc_pkg::MODE_EDGE:    sum = (ctr <<< 3) - edges - corners;
            rgbc_pkg::MODE_SHARPEN: sum = (ctr <<< 2) + ctr - edges;
            rgbc_pkg::MODE_BOX:     sum = ctr + edges + corners;
            rgbc_pkg::MODE_GAUSS:   sum = corners + (edges <<< 1) + (ctr <<< 2);
            default:                sum = '0;
        endcase
    end
endmodule
